FILE: hdl/arts_pkg.sv
// ----------------------------------------------------------------------------
// arts_pkg: shared types and constants
// Field widths, operation and status codes, and the stored record layout of
// the anchor range table.
// ----------------------------------------------------------------------------
package arts_pkg;

	localparam int ADDR_W  = 16;
	localparam int RANGE_W = 24;
	localparam int LEVEL_W = 12;
	localparam int SLOT_W  = 4;

	// sample + newest + previous, three Q15.8 values
	localparam int SUM_W = RANGE_W + 2;

	// floor(2^28 / 3); the estimate is never more than one below the quotient
	localparam int DIV3_SHIFT = 28;
	localparam logic [26:0] DIV3_K = 27'd89478485;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_ZERO_ADDR = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]                op;
		logic [ADDR_W-1:0]         anchor_key;
		logic signed [RANGE_W-1:0] range_sample;
		logic signed [LEVEL_W-1:0] signal_level;
	} item_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [RANGE_W-1:0] smoothed_range;
		logic [SLOT_W-1:0]         slot;
	} result_t;

	typedef struct packed {
		logic signed [RANGE_W-1:0] newest_range;
		logic signed [RANGE_W-1:0] previous_range;
		logic signed [LEVEL_W-1:0] level;
	} anchor_rec_t;

endpackage

FILE: hdl/arts_store.sv
// ----------------------------------------------------------------------------
// arts_store: anchor table storage
// Key memory and record memory, one write port and one registered read port
// each, sharing the addresses.
// ----------------------------------------------------------------------------
module arts_store #(
	parameter int SLOTS = 16,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                               clk,
	input  logic [IDX_W-1:0]                   rd_addr,
	output logic [arts_pkg::ADDR_W-1:0]        key_rd,
	output arts_pkg::anchor_rec_t              rec_rd,
	input  logic                               wr_key_en,
	input  logic                               wr_rec_en,
	input  logic [IDX_W-1:0]                   wr_addr,
	input  logic [arts_pkg::ADDR_W-1:0]        wr_key,
	input  arts_pkg::anchor_rec_t              wr_rec
);
	import arts_pkg::*;

	logic [ADDR_W-1:0] key_mem [SLOTS];
	anchor_rec_t       rec_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		key_rd <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_rec_en) begin
			rec_mem[wr_addr] <= wr_rec;
		end
		rec_rd <= rec_mem[rd_addr];
	end

endmodule

FILE: hdl/arts_div3.sv
// ----------------------------------------------------------------------------
// arts_div3: signed divide by three, truncating toward zero
// Two stages: reciprocal multiply on the magnitude, then a single
// compare-and-increment correction and the sign.
// ----------------------------------------------------------------------------
module arts_div3 (
	input  logic                                    clk,
	input  logic signed [arts_pkg::SUM_W-1:0]       sum,
	output logic signed [arts_pkg::RANGE_W-1:0]     avg
);
	import arts_pkg::*;

	localparam int Q_W    = SUM_W - 1;
	localparam int PROD_W = SUM_W + 27;

	logic [SUM_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0]    q0_s1;
	logic [SUM_W-1:0]  mag_s1;
	logic              neg_s1;
	logic [SUM_W:0]    rem;
	logic [Q_W-1:0]    q;
	logic [Q_W-1:0]    q_signed;

	always_comb begin
		mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		prod = PROD_W'(mag) * PROD_W'(DIV3_K);
	end

	always_ff @(posedge clk) begin
		q0_s1  <= prod[DIV3_SHIFT +: Q_W];
		mag_s1 <= mag;
		neg_s1 <= sum[SUM_W-1];
	end

	// remainder stays below six, so one step fixes the estimate
	always_comb begin
		rem      = (SUM_W+1)'(mag_s1) - ((SUM_W+1)'(q0_s1) * (SUM_W+1)'(3));
		q        = (rem >= (SUM_W+1)'(3)) ? q0_s1 + Q_W'(1) : q0_s1;
		q_signed = neg_s1 ? Q_W'(-q) : q;
	end

	always_ff @(posedge clk) begin
		avg <= q_signed[RANGE_W-1:0];
	end

endmodule

FILE: hdl/anchor_range_table_smoother.sv
// ----------------------------------------------------------------------------
// anchor_range_table_smoother: ordered anchor table with range smoothing
// Add, update and delete on a table of anchors kept in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//  A command is taken on a rising edge with start high and busy low. Each
//  command gives exactly one result, shown on result for one cycle with done
//  high; the receiver cannot stall, so it must take it then.
//  Add, zero address, undefined op and lookups on an empty table: done in the
//  cycle after the transfer, busy stays low.
//  Update that hits entry p: done after a linear search at one entry per
//  cycle through the key memory, the divide-by-three unit (S_DIV1, S_DIV2)
//  and the write-back state (S_WRB).
//  Delete of entry p with n entries: done after the search and the shift,
//  which moves one entry down per cycle.
//  Miss on update or delete: done after the search of all n entries.
//  A new command may be taken in the cycle that done is high.
//  Reset empties the table (entry count zero); memory contents are not
//  cleared, entries at or above the count are never used.
// ----------------------------------------------------------------------------
module anchor_range_table_smoother #(
	parameter int ANCHOR_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  arts_pkg::item_t   item,
	output logic              done,
	output arts_pkg::result_t result
);
	import arts_pkg::*;

	localparam int IDX_W = (ANCHOR_SLOTS > 1) ? $clog2(ANCHOR_SLOTS) : 1;
	localparam int CNT_W = $clog2(ANCHOR_SLOTS + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEARCH = 6'b000010,
		S_SHIFT  = 6'b000100,
		S_DIV1   = 6'b001000,
		S_DIV2   = 6'b010000,
		S_WRB    = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               done_q, done_d;
	result_t            res_q, res_d;

	item_t                     item_q;
	logic [IDX_W-1:0]          pos_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [RANGE_W-1:0] old_newest_q;

	logic                capture;
	logic                hit;
	logic                has_next;
	logic                has_next2;
	logic [IDX_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]   key_rd;
	anchor_rec_t         rec_rd;
	logic                wr_key_en;
	logic                wr_rec_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]   wr_key;
	anchor_rec_t         wr_rec;
	logic signed [RANGE_W-1:0] avg;

	arts_store #(.SLOTS(ANCHOR_SLOTS)) u_store (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.key_rd    (key_rd),
		.rec_rd    (rec_rd),
		.wr_key_en (wr_key_en),
		.wr_rec_en (wr_rec_en),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_rec    (wr_rec)
	);

	arts_div3 u_div3 (
		.clk (clk),
		.sum (sum_q),
		.avg (avg)
	);

	assign hit       = (key_rd == item_q.anchor_key);
	assign has_next  = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(1)) < (CNT_W+1)'(count_q);
	assign has_next2 = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(2)) < (CNT_W+1)'(count_q);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		done_d    = 1'b0;
		res_d     = '0;
		capture   = 1'b0;
		rd_addr   = idx_q + IDX_W'(1);
		wr_key_en = 1'b0;
		wr_rec_en = 1'b0;
		wr_addr   = idx_q;
		wr_key    = key_rd;
		wr_rec    = rec_rd;

		case (state_q)
			S_IDLE: begin
				rd_addr = '0;
				if (start) begin
					capture = 1'b1;
					case (item.op)
						OP_ADD: begin
							done_d = 1'b1;
							if (item.anchor_key == '0) begin
								res_d.status = ST_ZERO_ADDR;
							end else if (count_q == CNT_W'(ANCHOR_SLOTS)) begin
								res_d.status = ST_FULL;
							end else begin
								wr_key_en  = 1'b1;
								wr_rec_en  = 1'b1;
								wr_addr    = IDX_W'(count_q);
								wr_key     = item.anchor_key;
								wr_rec     = '0;
								count_d    = count_q + CNT_W'(1);
								res_d.slot = SLOT_W'(count_q);
							end
						end
						OP_UPDATE, OP_DELETE: begin
							if (item.anchor_key == '0) begin
								done_d       = 1'b1;
								res_d.status = ST_ZERO_ADDR;
							end else if (count_q == '0) begin
								done_d       = 1'b1;
								res_d.status = ST_NOT_FOUND;
							end else begin
								idx_d   = '0;
								state_d = S_SEARCH;
							end
						end
						default: begin
							done_d       = 1'b1;
							res_d.status = ST_NOT_FOUND;
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (hit) begin
					if (item_q.op == OP_UPDATE) begin
						state_d = S_DIV1;
					end else if (has_next) begin
						state_d = S_SHIFT;
					end else begin
						count_d    = count_q - CNT_W'(1);
						done_d     = 1'b1;
						res_d.slot = SLOT_W'(idx_q);
						state_d    = S_IDLE;
					end
				end else if (has_next) begin
					idx_d = idx_q + IDX_W'(1);
				end else begin
					done_d       = 1'b1;
					res_d.status = ST_NOT_FOUND;
					state_d      = S_IDLE;
				end
			end
			S_SHIFT: begin
				// read data holds entry idx+1; move it down one place
				wr_key_en = 1'b1;
				wr_rec_en = 1'b1;
				rd_addr   = idx_q + IDX_W'(2);
				if (has_next2) begin
					idx_d = idx_q + IDX_W'(1);
				end else begin
					count_d    = count_q - CNT_W'(1);
					done_d     = 1'b1;
					res_d.slot = SLOT_W'(pos_q);
					state_d    = S_IDLE;
				end
			end
			S_DIV1: begin
				state_d = S_DIV2;
			end
			S_DIV2: begin
				state_d = S_WRB;
			end
			S_WRB: begin
				wr_rec_en                  = 1'b1;
				wr_rec.newest_range        = avg;
				wr_rec.previous_range      = old_newest_q;
				wr_rec.level               = item_q.signal_level;
				done_d                     = 1'b1;
				res_d.smoothed_range       = avg;
				res_d.slot                 = SLOT_W'(idx_q);
				state_d                    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (capture) begin
			item_q <= item;
		end
		if ((state_q == S_SEARCH) && hit) begin
			pos_q        <= idx_q;
			old_newest_q <= rec_rd.newest_range;
			sum_q        <= SUM_W'(item_q.range_sample) + SUM_W'(rec_rd.newest_range)
			              + SUM_W'(rec_rd.previous_range);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ANCHOR_SLOTS))
		else $error("entry count above table size");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result shown while a command is still running");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.op == OP_ADD) && (item.anchor_key != '0)
		 && (count_q != CNT_W'(ANCHOR_SLOTS)))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted add did not grow the table");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (res_q.status != ST_OK))
		|-> ((res_q.slot == '0) && (res_q.smoothed_range == '0)))
		else $error("failed command reports a slot or range");

	a_shift_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> has_next)
		else $error("delete shift reads beyond the table");
`endif

endmodule
